// File: rtl/core/blf3_pkg.sv
// shared types and constants for the boundary label fill block
// no dependencies; compiled before every other file of the block
`default_nettype none

package blf3_pkg;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int LABEL_BITS_DEF = 16;

   // register port
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;

   localparam int RESET_IMAGE_WIDTH  = 640;
   localparam int RESET_IMAGE_HEIGHT = 480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   // per-push control carried from the front end to the window stage
   typedef struct packed {
      logic emit;
      logic eof;
      logic up_ok;
      logic down_ok;
      logic left_ok;
      logic right_ok;
   } push_ctl_type;

   // window stage occupancy, seen by the front end and the line buffer
   typedef struct packed {
      logic valid;
      logic move;
      logic free;
   } stage_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/blf3_if.sv
// request and response channel interfaces of the boundary label fill block
// depends on blf3_pkg
`default_nettype none

interface blf3_req_if #(
   parameter int LABEL_BITS = blf3_pkg::LABEL_BITS_DEF
);
   import blf3_pkg::*;

   logic                  valid;
   logic                  ready;
   func_type              func;
   logic [LABEL_BITS-1:0] pixel_label;

   modport source (output valid, func, pixel_label, input ready);
   modport sink   (input valid, func, pixel_label, output ready);
endinterface

interface blf3_rsp_if #(
   parameter int LABEL_BITS = blf3_pkg::LABEL_BITS_DEF
);
   import blf3_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [LABEL_BITS-1:0] filled_label;
   logic                  unfilled;
   logic                  end_of_frame;

   modport source (output valid, filled_label, unfilled, end_of_frame, input ready);
   modport sink   (input valid, filled_label, unfilled, end_of_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/core/blf3_ctrl.sv
// front end: image size registers, raster position counters, push decisions
// depends on blf3_pkg and blf3_req_if
`default_nettype none

module blf3_ctrl #(
   parameter int MAX_WIDTH  = blf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = blf3_pkg::MAX_HEIGHT_DEF,
   parameter int LABEL_BITS = blf3_pkg::LABEL_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   blf3_req_if.sink                             req,
   input  logic                                 csr_we,
   input  blf3_pkg::csr_index_type              csr_index,
   input  logic [blf3_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  blf3_pkg::stage_stat_type             stat,
   output logic                                 push_en,
   output logic [$clog2(MAX_WIDTH)-1:0]         push_col,
   output logic [LABEL_BITS-1:0]                push_label,
   output blf3_pkg::push_ctl_type               push_ctl
);
   import blf3_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);
   localparam int RST_W  = (RESET_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_IMAGE_WIDTH;
   localparam int RST_H  = (RESET_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_IMAGE_HEIGHT;

   logic [WID_W-1:0]  width_ff, width_in;
   logic [ROW_W-1:0]  height_ff, height_in;
   logic [WID_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PEND_W-1:0] pend_ff, pend_in;

   logic              tail;
   logic              auto_push;
   logic              take;
   logic              col_last;
   logic [WID_W-1:0]  col_step;
   logic [ROW_W-1:0]  row_step;
   logic              col_nz;
   logic              emit_pos;
   logic [WID_W-1:0]  width_wr;
   logic [ROW_W-1:0]  height_wr;

   // clamp written sizes into 1..MAX
   always_comb begin
      if (csr_wdata == '0) begin
         width_wr  = WID_W'(1);
         height_wr = ROW_W'(1);
      end else begin
         width_wr  = (32'(csr_wdata) > 32'(MAX_WIDTH))  ? WID_W'(MAX_WIDTH)  : WID_W'(csr_wdata);
         height_wr = (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(csr_wdata);
      end
   end

   // frame tail and the extra zero push a one-row frame needs there
   assign tail      = row_ff >= height_ff;
   assign auto_push = tail && (row_ff == ROW_W'(1)) && (col_ff == '0) && (pend_ff != '0);
   assign req.ready = stat.free && !auto_push;
   assign take      = req.valid && req.ready;

   assign col_last = (col_ff + WID_W'(1)) >= width_ff;
   assign col_step = col_last ? '0 : col_ff + WID_W'(1);
   assign row_step = col_last ? row_ff + ROW_W'(1) : row_ff;
   assign col_nz   = col_ff != '0;
   assign emit_pos = col_nz ? (row_ff >= ROW_W'(1)) : (row_ff >= ROW_W'(2));

   assign push_col = col_ff[COL_W-1:0];

   // neighbor masks for the pixel that this push completes
   always_comb begin
      push_ctl.emit = emit_pos;
      push_ctl.eof  = tail && (pend_ff == PEND_W'(1));
      if (col_nz) begin
         push_ctl.up_ok    = row_ff >= ROW_W'(2);
         push_ctl.down_ok  = row_ff < height_ff;
         push_ctl.left_ok  = col_ff >= WID_W'(2);
         push_ctl.right_ok = 1'b1;
      end else begin
         push_ctl.up_ok    = row_ff >= ROW_W'(3);
         push_ctl.down_ok  = row_ff <= height_ff;
         push_ctl.left_ok  = width_ff >= WID_W'(2);
         push_ctl.right_ok = 1'b0;
      end
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pend_in    = pend_ff;
      push_en    = 1'b0;
      push_label = '0;
      priority if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = width_wr;
            CSR_IMAGE_HEIGHT: height_in = height_wr;
            default:          width_in  = width_ff;
         endcase
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (auto_push && stat.free) begin
         push_en = 1'b1;
         col_in  = col_step;
         row_in  = row_step;
      end else if (take && tail) begin
         if (pend_ff == '0) begin
            col_in = '0;
            row_in = '0;
         end else begin
            push_en = 1'b1;
            pend_in = pend_ff - PEND_W'(1);
            if (pend_ff == PEND_W'(1)) begin
               col_in = '0;
               row_in = '0;
            end else begin
               col_in = col_step;
               row_in = row_step;
            end
         end
      end else if (take && (req.func == FUNC_PIXEL)) begin
         push_en    = 1'b1;
         push_label = req.pixel_label;
         pend_in    = emit_pos ? pend_ff : pend_ff + PEND_W'(1);
         col_in     = col_step;
         row_in     = row_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(RST_W);
         height_ff <= ROW_W'(RST_H);
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/blf3_line_buf.sv
// two line buffers kept as one memory of label pairs, with write forwarding
// depends on blf3_pkg
`default_nettype none

module blf3_line_buf #(
   parameter int MAX_WIDTH  = blf3_pkg::MAX_WIDTH_DEF,
   parameter int LABEL_BITS = blf3_pkg::LABEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  push_col,
   input  logic [LABEL_BITS-1:0]         push_label,
   input  blf3_pkg::stage_stat_type      stat,
   output logic [LABEL_BITS-1:0]         col_above,
   output logic [LABEL_BITS-1:0]         col_center,
   output logic [LABEL_BITS-1:0]         col_below
);
   import blf3_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ENTRY_W = 2 * LABEL_BITS;

   // entry = {row above, row center}
   logic [ENTRY_W-1:0]    mem [MAX_WIDTH];
   logic [ENTRY_W-1:0]    rd_ff;
   logic [ENTRY_W-1:0]    prev_ff;
   logic                  hit_ff, hit_in;
   logic [COL_W-1:0]      col_ff;
   logic [LABEL_BITS-1:0] label_ff;
   logic [ENTRY_W-1:0]    eff;
   logic [ENTRY_W-1:0]    wr_data;

   // a push to the column being written back in the same cycle reads stale data
   assign hit_in = push_en && stat.valid && (col_ff == push_col);

   assign eff        = hit_ff ? prev_ff : rd_ff;
   assign col_above  = eff[ENTRY_W-1:LABEL_BITS];
   assign col_center = eff[LABEL_BITS-1:0];
   assign col_below  = label_ff;
   assign wr_data    = {col_center, label_ff};

   always_ff @(posedge clock) begin
      if (push_en) begin
         rd_ff    <= mem[push_col];
         col_ff   <= push_col;
         label_ff <= push_label;
      end
      if (stat.move) begin
         mem[col_ff] <= wr_data;
         prev_ff     <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (push_en) begin
         hit_ff <= hit_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/blf3_window.sv
// 3x3 window stage, neighbor fill selection and the result register
// depends on blf3_pkg and blf3_rsp_if
`default_nettype none

module blf3_window #(
   parameter int LABEL_BITS = blf3_pkg::LABEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_en,
   input  blf3_pkg::push_ctl_type    push_ctl,
   input  logic [LABEL_BITS-1:0]     col_above,
   input  logic [LABEL_BITS-1:0]     col_center,
   input  logic [LABEL_BITS-1:0]     col_below,
   output blf3_pkg::stage_stat_type  stat,
   blf3_rsp_if.source                rsp
);
   import blf3_pkg::*;

   logic                  s1_v_ff, s1_v_in;
   push_ctl_type          ctl_ff;
   logic [LABEL_BITS-1:0] win_ff [9];
   logic [LABEL_BITS-1:0] win_in [9];
   logic                  out_v_ff, out_v_in;
   logic [LABEL_BITS-1:0] label_ff;
   logic                  unfilled_ff;
   logic                  eof_ff;
   logic                  out_can;
   logic                  out_load;
   logic [LABEL_BITS-1:0] fill;

   assign out_can    = !out_v_ff || rsp.ready;
   assign stat.valid = s1_v_ff;
   assign stat.move  = s1_v_ff && (!ctl_ff.emit || out_can);
   assign stat.free  = !s1_v_ff || stat.move;
   assign out_load   = stat.move && ctl_ff.emit;

   assign s1_v_in  = push_en || (s1_v_ff && !stat.move);
   assign out_v_in = out_load || (out_v_ff && !rsp.ready);

   // shift left one column, new column on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[3*k]     = win_ff[3*k+1];
         win_in[3*k + 1] = win_ff[3*k+2];
      end
      win_in[2] = col_above;
      win_in[5] = col_center;
      win_in[8] = col_below;
   end

   // own label first, then edge neighbors, then corners
   always_comb begin
      priority if (win_in[4] != '0)                                 fill = win_in[4];
      else if (ctl_ff.up_ok && win_in[1] != '0)                     fill = win_in[1];
      else if (ctl_ff.down_ok && win_in[7] != '0)                   fill = win_in[7];
      else if (ctl_ff.left_ok && win_in[3] != '0)                   fill = win_in[3];
      else if (ctl_ff.right_ok && win_in[5] != '0)                  fill = win_in[5];
      else if (ctl_ff.up_ok && ctl_ff.left_ok && win_in[0] != '0)    fill = win_in[0];
      else if (ctl_ff.up_ok && ctl_ff.right_ok && win_in[2] != '0)   fill = win_in[2];
      else if (ctl_ff.down_ok && ctl_ff.left_ok && win_in[6] != '0)  fill = win_in[6];
      else if (ctl_ff.down_ok && ctl_ff.right_ok && win_in[8] != '0) fill = win_in[8];
      else                                                          fill = '0;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         ctl_ff <= push_ctl;
      end
      if (stat.move) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
      if (out_load) begin
         label_ff    <= fill;
         unfilled_ff <= (fill == '0);
         eof_ff      <= ctl_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.filled_label = label_ff;
   assign rsp.unfilled     = unfilled_ff;
   assign rsp.end_of_frame = eof_ff;

endmodule

`default_nettype wire

// File: rtl/core/boundary_label_fill_3x3.sv
// boundary label fill: fills zero-labeled pixels from a 3x3 neighborhood
// depends on blf3_pkg, blf3_if, blf3_ctrl, blf3_line_buf, blf3_window
//
// usage
//   req_chan carries one item per transfer: func selects a pixel label
//   (the next raster pixel) or a drain item. rsp_chan returns the filled
//   label, an unfilled flag and end_of_frame on the frame's last pixel.
//   csr_we/csr_index/csr_wdata write image_width and image_height; each
//   write restarts the stream, so write only while no results are owed.
//   outputs lag their pixel by one row plus one pixel; after the frame's
//   last pixel, each further transfer (drain or pixel) flushes one result.
// timing
//   one item per clock while rsp_chan keeps up; a result passes the
//   memory read register, then window and fill into the output register.
//   a one-row frame drops req_chan.ready at its end for an extra push.
// reset
//   synchronous, active high; sizes go to 640x480 and counters clear.
//   line buffer contents are not cleared and are never used unwritten.
// stalls
//   a held result sits in the output register; one more item fits in the
//   window stage before req_chan.ready drops.
`default_nettype none

module boundary_label_fill_3x3 #(
   parameter int MAX_WIDTH  = blf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = blf3_pkg::MAX_HEIGHT_DEF,
   parameter int LABEL_BITS = blf3_pkg::LABEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   blf3_req_if.sink                            req_chan,
   blf3_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  blf3_pkg::csr_index_type             csr_index,
   input  logic [blf3_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import blf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // front end to line buffer and window
   logic                  push_en;
   logic [COL_W-1:0]      push_col;
   logic [LABEL_BITS-1:0] push_label;
   push_ctl_type          push_ctl;

   // window stage occupancy, drives backpressure and buffer write-back
   stage_stat_type        stat;

   // new window column
   logic [LABEL_BITS-1:0] col_above;
   logic [LABEL_BITS-1:0] col_center;
   logic [LABEL_BITS-1:0] col_below;

   // counters, size registers, drain/tail handling
   blf3_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .LABEL_BITS (LABEL_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .push_en    (push_en),
      .push_col   (push_col),
      .push_label (push_label),
      .push_ctl   (push_ctl)
   );

   // two rows of history, read on push, written back from the window stage
   blf3_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .LABEL_BITS (LABEL_BITS)
   ) u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_col   (push_col),
      .push_label (push_label),
      .stat       (stat),
      .col_above  (col_above),
      .col_center (col_center),
      .col_below  (col_below)
   );

   // 3x3 window, fill priority and output register
   blf3_window #(
      .LABEL_BITS (LABEL_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_ctl   (push_ctl),
      .col_above  (col_above),
      .col_center (col_center),
      .col_below  (col_below),
      .stat       (stat),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/boundary_label_fill_3x3_test.sv
// self-checking bench for boundary_label_fill_3x3: directed steps, then random frames
// carries its own fill predictor and compares every response transfer against it
// depends on blf3_pkg, blf3_if and the boundary_label_fill_3x3 rtl

module boundary_label_fill_3x3_test;
   import blf3_pkg::*;

   localparam int LBITS         = LABEL_BITS_DEF;
   localparam int MAXW          = MAX_WIDTH_DEF;
   localparam int MAXH          = MAX_HEIGHT_DEF;
   localparam int RANDOM_ITEMS  = 950;
   // a result passes the memory read and output registers; leave a margin on top
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [LBITS-1:0] label;
      logic             unfilled;
      logic             eof;
   } fill_result_t;

   typedef enum logic [1:0] {
      STEP_WRITE,    // size register write
      STEP_ITEM,     // item checked against the predictor
      STEP_CHECKED   // item with its result typed into the table
   } step_kind_t;

   typedef struct packed {
      step_kind_t                 kind;
      csr_index_type              idx;
      logic [CSR_DATA_BITS-1:0]   value;
      func_type                   func;
      logic [LBITS-1:0]           label;
      logic [LBITS-1:0]           exp_label;
      logic                       exp_unfilled;
      logic                       exp_eof;
   } directed_step_t;

   typedef enum logic [1:0] {
      RSP_OPEN,         // always ready
      RSP_COIN,         // ready on a coin toss
      RSP_ONE_IN_FOUR,  // stalls whenever hold_left is a multiple of four
      RSP_LONG_HOLD     // stalls while hold_left mod 16 is below eight
   } rsp_mode_t;

   // directed steps: reset-size corner cases, 1x1 frames with known results,
   // then one 3x3 frame and its tail
   localparam directed_step_t DIRECTED_STEPS [0:23] = '{
      // drain mid-frame right after reset is dropped
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_DRAIN, 16'h0000, 16'h0000, 1'b0, 1'b0},
      // first pixel of a 640-wide frame only warms up the window
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'hFFFF, 16'h0000, 1'b0, 1'b0},
      // zero sizes clamp to a 1x1 frame
      '{STEP_WRITE,   CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_WRITE,   CSR_IMAGE_HEIGHT, 11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'hFFFF, 16'h0000, 1'b0, 1'b0},
      '{STEP_CHECKED, CSR_IMAGE_WIDTH,  11'd0, FUNC_DRAIN, 16'h0000, 16'hFFFF, 1'b0, 1'b1},
      // lone boundary pixel stays unfilled; the tail ignores a pixel's label
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_CHECKED, CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h1234, 16'h0000, 1'b1, 1'b1},
      '{STEP_WRITE,   CSR_IMAGE_WIDTH,  11'd3, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_WRITE,   CSR_IMAGE_HEIGHT, 11'd3, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      // 3x3 frame mixing boundary pixels with extreme labels
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0001, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h8000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'hFFFF, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h00FF, 16'h0000, 1'b0, 1'b0},
      // tail: one row plus one pixel still owed
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_DRAIN, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_DRAIN, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_PIXEL, 16'h7E57, 16'h0000, 1'b0, 1'b0},
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_DRAIN, 16'h0000, 16'h0000, 1'b0, 1'b0},
      // new frame has begun, so this drain is dropped
      '{STEP_ITEM,    CSR_IMAGE_WIDTH,  11'd0, FUNC_DRAIN, 16'h0000, 16'h0000, 1'b0, 1'b0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   blf3_req_if req_chan ();
   blf3_rsp_if rsp_chan ();

   boundary_label_fill_3x3 dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // fill predictor: line buffers, 3x3 window and stream position
   // ---------------------------------------------------------------
   logic [LBITS-1:0] prev_line [MAXW];
   logic [LBITS-1:0] cur_line  [MAXW];
   logic [LBITS-1:0] nbhd      [9];
   int unsigned      push_col;
   int unsigned      push_row;
   int unsigned      owed_fills;
   int unsigned      cfg_width;
   int unsigned      cfg_height;

   fill_result_t expected_fills [$];
   int unsigned  fill_mismatches = 0;
   int unsigned  burst_left = 0;

   function automatic void restart_fill_model();
      for (int k = 0; k < 9; k++) nbhd[k] = '0;
      push_col   = 0;
      push_row   = 0;
      owed_fills = 0;
   endfunction

   function automatic void reset_fill_model();
      cfg_width  = RESET_IMAGE_WIDTH;
      cfg_height = RESET_IMAGE_HEIGHT;
      for (int k = 0; k < MAXW; k++) begin
         prev_line[k] = '0;
         cur_line[k]  = '0;
      end
      restart_fill_model();
   endfunction

   function automatic int unsigned clamp_side(logic [CSR_DATA_BITS-1:0] value, int unsigned most);
      int unsigned v;
      v = value;
      if (v == 0) v = 1;
      if (v > most) v = most;
      return v;
   endfunction

   // shift one pixel into the window; reports the pixel now centered, if any
   function automatic bit shift_in(input logic [LBITS-1:0] lbl,
                                   output int unsigned orow, output int unsigned ocol);
      int unsigned      c;
      logic [LBITS-1:0] above, mid;
      bit               centered;
      c = (push_col >= MAXW) ? MAXW - 1 : push_col;
      above = prev_line[c];
      mid   = cur_line[c];
      prev_line[c] = mid;
      cur_line[c]  = lbl;
      for (int k = 0; k < 3; k++) begin
         nbhd[k*3]   = nbhd[k*3+1];
         nbhd[k*3+1] = nbhd[k*3+2];
      end
      nbhd[2] = above;
      nbhd[5] = mid;
      nbhd[8] = lbl;
      centered = 1'b0;
      orow = 0;
      ocol = 0;
      if (push_col >= 1) begin
         if (push_row >= 1) begin
            orow = push_row - 1;
            ocol = push_col - 1;
            centered = 1'b1;
         end
      end else if (push_row >= 2) begin
         // first column of a row completes the last pixel two rows up
         orow = push_row - 2;
         ocol = cfg_width - 1;
         centered = 1'b1;
      end
      push_col++;
      if (push_col >= cfg_width) begin
         push_col = 0;
         push_row++;
      end
      return centered;
   endfunction

   // neighbor priority: up, down, left, right, then the four diagonals
   function automatic fill_result_t fill_at(int unsigned orow, int unsigned ocol);
      bit               up, dn, lf, rt;
      logic [LBITS-1:0] v;
      fill_result_t     r;
      up = orow > 0;
      dn = orow + 1 < cfg_height;
      lf = ocol > 0;
      rt = ocol + 1 < cfg_width;
      v  = '0;
      if (nbhd[4] != 0)                   v = nbhd[4];
      else if (up && nbhd[1] != 0)        v = nbhd[1];
      else if (dn && nbhd[7] != 0)        v = nbhd[7];
      else if (lf && nbhd[3] != 0)        v = nbhd[3];
      else if (rt && nbhd[5] != 0)        v = nbhd[5];
      else if (up && lf && nbhd[0] != 0)  v = nbhd[0];
      else if (up && rt && nbhd[2] != 0)  v = nbhd[2];
      else if (dn && lf && nbhd[6] != 0)  v = nbhd[6];
      else if (dn && rt && nbhd[8] != 0)  v = nbhd[8];
      r.label    = v;
      r.unfilled = (v == 0);
      r.eof      = 1'b0;
      return r;
   endfunction

   // advance the predictor by one accepted item; returns 1 when it owes a result
   function automatic bit advance_fill_model(input func_type f, input logic [LBITS-1:0] lbl,
                                             output fill_result_t fill);
      int unsigned orow, ocol, g;
      fill = '0;
      orow = 0;
      ocol = 0;
      if (push_row >= cfg_height) begin
         // tail: push zeros until one pixel comes out, whatever the item is
         if (owed_fills == 0) begin
            restart_fill_model();
            return 1'b0;
         end
         for (g = 0; g < MAXW + 2; g++)
            if (shift_in('0, orow, ocol)) break;
         fill = fill_at(orow, ocol);
         owed_fills--;
         if (owed_fills == 0) begin
            fill.eof = 1'b1;
            push_col = 0;
            push_row = 0;
         end
         return 1'b1;
      end
      if (f == FUNC_DRAIN) return 1'b0;
      owed_fills++;
      if (shift_in(lbl, orow, ocol)) begin
         fill = fill_at(orow, ocol);
         owed_fills--;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one request transfer; the sender runs in bursts with random gaps between them
   task automatic offer(input func_type f, input logic [LBITS-1:0] lbl,
                        input bit typed = 1'b0, input fill_result_t typed_fill = '0);
      int unsigned  gap;
      fill_result_t fill;
      bit           owes;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.func        <= f;
      req_chan.pixel_label <= lbl;
      do @(posedge clock); while (!req_chan.ready);
      // transfer happened at this edge
      owes = advance_fill_model(f, lbl, fill);
      if (typed) expected_fills.push_back(typed_fill);
      else if (owes) expected_fills.push_back(fill);
   endtask

   // hold the sender until every owed result is back, then let the pipe settle
   task automatic wait_for_fills();
      req_chan.valid <= 1'b0;
      while (expected_fills.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // size writes only go in while the block is idle; each restarts the stream
   task automatic write_size(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      wait_for_fills();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) cfg_width = clamp_side(value, MAXW);
      else cfg_height = clamp_side(value, MAXH);
      restart_fill_model();
      csr_we <= 1'b0;
   endtask

   // half boundary pixels, a few repeated region labels, the rest anything
   function automatic logic [LBITS-1:0] pick_label();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return '0;
         5, 6, 7: begin
            case ($urandom_range(0, 3))
               0:       return 16'h0001;
               1:       return 16'hFFFF;
               2:       return 16'h8000;
               default: return 16'h5A5A;
            endcase
         end
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_side(int unsigned most);
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return 1;
         2:       return 2;
         default: return $urandom_range(1, most);
      endcase
   endfunction

   // send cut pixels of the current frame; a full frame is followed by its tail
   task automatic run_frame(input int unsigned cut, inout int unsigned counted);
      int unsigned p;
      for (p = 0; p < cut; p++) begin
         // stray drain mid-frame, dropped by the block
         if ($urandom_range(0, 19) == 0) offer(FUNC_DRAIN, pick_label());
         offer(FUNC_PIXEL, pick_label());
         counted++;
         if ($urandom_range(0, 299) == 0) wait_for_fills();
      end
      while (push_row >= cfg_height) begin
         offer(($urandom_range(0, 4) == 0) ? FUNC_PIXEL : FUNC_DRAIN, pick_label());
         counted++;
      end
   endtask

   // ---------------------------------------------------------------
   // response checker: every result against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      fill_result_t got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.label    = rsp_chan.filled_label;
         got.unfilled = rsp_chan.unfilled;
         got.eof      = rsp_chan.end_of_frame;
         if (expected_fills.size() == 0) begin
            fill_mismatches++;
            if (fill_mismatches <= 10)
               $display("unexpected result: label %h unfilled %b eof %b",
                        got.label, got.unfilled, got.eof);
         end else begin
            want = expected_fills.pop_front();
            if (got.label !== want.label || got.unfilled !== want.unfilled ||
                got.eof !== want.eof) begin
               fill_mismatches++;
               if (fill_mismatches <= 10)
                  $display("mismatch: expected label %h unfilled %b eof %b, got %h %b %b",
                           want.label, want.unfilled, want.eof,
                           got.label, got.unfilled, got.eof);
            end
         end
      end
   end

   // receiver: picks a new stall pattern whenever its random hold count runs out
   initial begin
      rsp_mode_t   hold_mode;
      int unsigned hold_left;
      hold_mode = RSP_OPEN;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0) begin
            hold_mode = rsp_mode_t'($urandom_range(0, 3));
            hold_left = $urandom_range(16, 160);
         end
         hold_left--;
         case (hold_mode)
            RSP_OPEN:        rsp_chan.ready <= 1'b1;
            RSP_COIN:        rsp_chan.ready <= $urandom_range(0, 1);
            RSP_ONE_IN_FOUR: rsp_chan.ready <= (hold_left % 4 != 0);
            default:         rsp_chan.ready <= (hold_left % 16 >= 8);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      directed_step_t step;
      fill_result_t   typed_fill;
      int unsigned    counted, n, cut;
      bit             stale;

      req_chan.valid       <= 1'b0;
      req_chan.func        <= FUNC_PIXEL;
      req_chan.pixel_label <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= '0;
      reset_fill_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED_STEPS[i]) begin
         step = DIRECTED_STEPS[i];
         case (step.kind)
            STEP_WRITE: write_size(step.idx, step.value);
            STEP_ITEM:  offer(step.func, step.label);
            default: begin
               typed_fill.label    = step.exp_label;
               typed_fill.unfilled = step.exp_unfilled;
               typed_fill.eof      = step.exp_eof;
               offer(step.func, step.label, 1'b1, typed_fill);
            end
         endcase
      end

      // random frames of small sizes; some are cut short and need a restart
      counted = 0;
      stale   = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (stale || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
               0: write_size(CSR_IMAGE_WIDTH, pick_side(12));
               1: write_size(CSR_IMAGE_HEIGHT, pick_side(8));
               default: begin
                  write_size(CSR_IMAGE_WIDTH, pick_side(12));
                  write_size(CSR_IMAGE_HEIGHT, pick_side(8));
               end
            endcase
         end
         n     = cfg_width * cfg_height;
         stale = ($urandom_range(0, 9) == 0);
         cut   = stale ? $urandom_range(0, n - 1) : n;
         run_frame(cut, counted);
      end

      // largest sizes: full-width single row, full-height single column,
      // then the head of a frame at both maxima
      write_size(CSR_IMAGE_WIDTH, 11'h7FF);
      write_size(CSR_IMAGE_HEIGHT, 11'd1);
      run_frame(cfg_width * cfg_height, counted);
      write_size(CSR_IMAGE_WIDTH, 11'd1);
      write_size(CSR_IMAGE_HEIGHT, 11'd1024);
      run_frame(cfg_width * cfg_height, counted);
      write_size(CSR_IMAGE_WIDTH, 11'd1024);
      write_size(CSR_IMAGE_HEIGHT, 11'h7FF);
      run_frame(1100, counted);

      wait_for_fills();
      if (fill_mismatches == 0 && expected_fills.size() == 0) begin
         $display("boundary_label_fill_3x3_test: clean");
      end else begin
         $display("boundary_label_fill_3x3_test: errors");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #2000000;
      $display("boundary_label_fill_3x3_test: errors");
      $finish;
   end

endmodule
